// File: hdl/ugrq_pkg.sv
`default_nettype none
package ugrq_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int MAX_CELLS  = 1024;
  localparam int HIT_LIMIT  = 32;

  localparam int PT_AW   = $clog2(MAX_POINTS);
  localparam int PT_CW   = PT_AW + 1;
  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int CELL_W  = 12;
  localparam int BND_W   = 27;

  localparam logic [PT_CW-1:0] END_LINK = '1;

  localparam logic [2:0] CFG_GRID_COLS  = 3'd0;
  localparam logic [2:0] CFG_GRID_ROWS  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_X   = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_Z   = 3'd3;
  localparam logic [2:0] CFG_CELL_SHIFT = 3'd4;

  localparam logic [5:0] DEFAULT_GRID = 6'd16;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    STATUS_CELL    = 2'd0,
    STATUS_OUTSIDE = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    req_kind_e          kind;
    logic signed [31:0] id;
    logic signed [23:0] x;
    logic signed [23:0] z;
    logic [47:0]        rsq;
    logic [5:0]         lim;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               hit_valid;
    logic signed [31:0] hit_id;
    logic [5:0]         hit_count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [5:0]         cols;
    logic [5:0]         rows;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_z;
    logic [4:0]         shift;
  } cfg_t;

  // Division by a power of two that truncates toward zero.
  function automatic logic signed [BND_W-1:0] div_trunc(input logic signed [BND_W-1:0] d,
                                                        input logic [4:0] sh);
    logic [BND_W-1:0] mag;
    logic [BND_W-1:0] q;
    mag = d[BND_W-1] ? BND_W'(-d) : BND_W'(d);
    q   = mag >> sh;
    return d[BND_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic res_t plain_res(input status_e st);
    res_t r;
    r.status    = st;
    r.hit_valid = 1'b0;
    r.hit_id    = '0;
    r.hit_count = '0;
    r.last      = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ugrq_front.sv
`default_nettype none
// Input queue: takes requests, drops the unused request code and clamps the hit limit.
module ugrq_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic signed [31:0] obj_id_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic [47:0]        radius_sq_i,
  input  wire logic [5:0]         max_hits_i,
  output logic                    req_valid_o,
  output ugrq_pkg::req_t          req_o,
  input  wire logic               req_pop_i
);
  ugrq_pkg::req_t mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       wr, rd;
  ugrq_pkg::req_t item;

  assign full_o      = (cnt_q == 3'd4);
  assign req_valid_o = (cnt_q != 3'd0);
  assign req_o       = mem_q[rptr_q];
  assign rd          = req_pop_i && req_valid_o;
  assign wr          = push_i && !full_o && (req_type_i != ugrq_pkg::REQ_UNUSED);

  always_comb begin
    item.kind = ugrq_pkg::req_kind_e'(req_type_i);
    item.id   = obj_id_i;
    item.x    = pos_x_i;
    item.z    = pos_z_i;
    item.rsq  = radius_sq_i;
    item.lim  = (max_hits_i > 6'(ugrq_pkg::HIT_LIMIT)) ? 6'(ugrq_pkg::HIT_LIMIT) : max_hits_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 2'd1;
      if (rd) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr) - 3'(rd);
    end
  end
endmodule
`default_nettype wire

// File: hdl/ugrq_isqrt.sv
`default_nettype none
// Floor square root, two radicand bits per cycle.
module ugrq_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] val_i,
  output logic             done_o,
  output logic [23:0]      root_o
);
  logic        busy_q;
  logic [4:0]  n_q;
  logic [47:0] val_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [27:0] rem_sh, trial;
  logic        take;

  assign rem_sh = {rem_q, val_q[47:46]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);
  assign done_o = busy_q && (n_q == 5'd23);
  assign root_o = {root_q[22:0], take};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[45:0], 2'b00};
      rem_q  <= take ? 26'(rem_sh - trial) : 26'(rem_sh);
      root_q <= {root_q[22:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      n_q    <= '0;
    end else if (busy_q) begin
      n_q <= n_q + 5'd1;
      if (done_o) busy_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hdl/ugrq_engine.sv
`default_nettype none
// Back end: point store, cell heads and the request sequencer.
module ugrq_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ugrq_pkg::cfg_t cfg_i,
  input  wire logic           req_valid_i,
  input  wire ugrq_pkg::req_t req_i,
  output logic                req_pop_o,
  output logic                res_valid_o,
  output ugrq_pkg::res_t      res_o,
  input  wire logic           res_ready_i
);
  localparam int AW = ugrq_pkg::PT_AW;
  localparam int CW = ugrq_pkg::PT_CW;
  localparam int BW = ugrq_pkg::BND_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_REG0  = 4'd2;
  localparam logic [3:0] S_REG1  = 4'd3;
  localparam logic [3:0] S_REG2  = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_BOUND = 4'd7;
  localparam logic [3:0] S_CELL  = 4'd8;
  localparam logic [3:0] S_HEAD  = 4'd9;
  localparam logic [3:0] S_WALK  = 4'd10;
  localparam logic [3:0] S_PDATA = 4'd11;
  localparam logic [3:0] S_PCMP  = 4'd12;
  localparam logic [3:0] S_NEXT  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  typedef struct packed {
    logic [CW-1:0]      next;
    logic signed [31:0] id;
    logic signed [23:0] z;
    logic signed [23:0] x;
  } pt_t;

  pt_t         pt_mem [ugrq_pkg::MAX_POINTS];
  logic [CW-1:0] head_mem [ugrq_pkg::MAX_CELLS];
  pt_t         pt_rd_q;
  logic [CW-1:0] head_rd_q;

  logic                         pt_we, pt_re, head_we, head_re;
  logic [AW-1:0]                pt_waddr, pt_raddr;
  pt_t                          pt_wdata;
  logic [ugrq_pkg::CELL_AW-1:0] head_waddr, head_raddr;
  logic [CW-1:0]                head_wdata;

  logic [3:0]  state_q, state_d;
  ugrq_pkg::req_t req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [ugrq_pkg::CELL_AW-1:0] clr_idx_q, clr_idx_d;
  logic        clr_res_q, clr_res_d;
  logic signed [BW-1:0] colw_q, colw_d, roww_q, roww_d;
  logic [ugrq_pkg::CELL_W-1:0] cell_q, cell_d;
  logic        ingrid_q, ingrid_d;
  logic [23:0] rad_q, rad_d;
  logic [5:0]  c0_q, c0_d, c1_q, c1_d, r0_q, r0_d, r1_q, r1_d, row_q, row_d, col_q, col_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [49:0] sqx_q, sqx_d, sqz_q, sqz_d;
  logic signed [31:0] cid_q, cid_d, pid_q, pid_d;
  logic [CW-1:0] cnext_q, cnext_d;
  logic        pv_q, pv_d;
  logic [5:0]  pcnt_q, pcnt_d;
  ugrq_pkg::res_t rq_q, rq_d;

  logic        sq_start, sq_done;
  logic [23:0] sq_root;

  logic signed [BW-1:0] cols_s, rows_s, c0w, c1w, r0w, r1w, c0c, c1c, r0c, r1c;
  logic [ugrq_pkg::CELL_W-1:0] cell_now;
  logic signed [24:0] dx, dz;
  logic [24:0] adx, adz;
  logic        hit;
  ugrq_pkg::res_t pend_res;

  ugrq_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .val_i  (req_i.rsq),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rd_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_rd_q <= head_mem[head_raddr];
  end

  assign cols_s   = $signed({{(BW-6){1'b0}}, cfg_i.cols});
  assign rows_s   = $signed({{(BW-6){1'b0}}, cfg_i.rows});
  assign cell_now = ({6'b0, row_q} * {6'b0, cfg_i.cols}) + {6'b0, col_q};

  always_comb begin
    c0w = ugrq_pkg::div_trunc($signed({{3{req_q.x[23]}}, req_q.x}) - $signed({3'b0, rad_q})
                              - $signed({{3{cfg_i.origin_x[23]}}, cfg_i.origin_x}), cfg_i.shift);
    c1w = ugrq_pkg::div_trunc($signed({{3{req_q.x[23]}}, req_q.x}) + $signed({3'b0, rad_q})
                              - $signed({{3{cfg_i.origin_x[23]}}, cfg_i.origin_x}), cfg_i.shift);
    r0w = ugrq_pkg::div_trunc($signed({{3{req_q.z[23]}}, req_q.z}) - $signed({3'b0, rad_q})
                              - $signed({{3{cfg_i.origin_z[23]}}, cfg_i.origin_z}), cfg_i.shift);
    r1w = ugrq_pkg::div_trunc($signed({{3{req_q.z[23]}}, req_q.z}) + $signed({3'b0, rad_q})
                              - $signed({{3{cfg_i.origin_z[23]}}, cfg_i.origin_z}), cfg_i.shift);
    c0c = c0w[BW-1] ? '0 : c0w;
    r0c = r0w[BW-1] ? '0 : r0w;
    c1c = (c1w >= cols_s) ? cols_s - BW'(1) : c1w;
    r1c = (r1w >= rows_s) ? rows_s - BW'(1) : r1w;
  end

  assign dx  = $signed({pt_rd_q.x[23], pt_rd_q.x}) - $signed({req_q.x[23], req_q.x});
  assign dz  = $signed({pt_rd_q.z[23], pt_rd_q.z}) - $signed({req_q.z[23], req_q.z});
  assign adx = dx[24] ? 25'(-dx) : 25'(dx);
  assign adz = dz[24] ? 25'(-dz) : 25'(dz);
  assign hit = (sqx_q + sqz_q) <= {2'b00, req_q.rsq};

  always_comb begin
    pend_res.status    = ugrq_pkg::STATUS_CELL;
    pend_res.hit_valid = 1'b1;
    pend_res.hit_id    = pid_q;
    pend_res.hit_count = pcnt_q;
    pend_res.last      = 1'b0;
  end

  always_comb begin
    state_d = state_q;  req_d = req_q;  cnt_d = cnt_q;
    clr_idx_d = clr_idx_q;  clr_res_d = clr_res_q;
    colw_d = colw_q;  roww_d = roww_q;  cell_d = cell_q;  ingrid_d = ingrid_q;
    rad_d = rad_q;  c0_d = c0_q;  c1_d = c1_q;  r0_d = r0_q;  r1_d = r1_q;
    row_d = row_q;  col_d = col_q;  cur_d = cur_q;
    sqx_d = sqx_q;  sqz_d = sqz_q;  cid_d = cid_q;  cnext_d = cnext_q;
    pv_d = pv_q;  pid_d = pid_q;  pcnt_d = pcnt_q;  rq_d = rq_q;
    req_pop_o = 1'b0;  sq_start = 1'b0;
    res_valid_o = 1'b0;  res_o = rq_q;
    pt_we = 1'b0;  pt_re = 1'b0;  pt_waddr = cnt_q[AW-1:0];  pt_raddr = cur_q[AW-1:0];
    pt_wdata.next = ingrid_q ? head_rd_q : ugrq_pkg::END_LINK;
    pt_wdata.id = req_q.id;  pt_wdata.z = req_q.z;  pt_wdata.x = req_q.x;
    head_we = 1'b0;  head_re = 1'b0;
    head_waddr = clr_idx_q;  head_wdata = ugrq_pkg::END_LINK;
    head_raddr = cell_now[ugrq_pkg::CELL_AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          req_d     = req_i;
          case (req_i.kind)
            ugrq_pkg::REQ_REGISTER: begin
              if (cnt_q == CW'(ugrq_pkg::MAX_POINTS)) begin
                rq_d    = ugrq_pkg::plain_res(ugrq_pkg::STATUS_FULL);
                state_d = S_EMIT;
              end else begin
                state_d = S_REG0;
              end
            end
            ugrq_pkg::REQ_QUERY: begin
              pcnt_d = '0;
              pv_d   = 1'b0;
              if (req_i.lim == 6'd0 || cnt_q == '0) begin
                rq_d    = ugrq_pkg::plain_res(ugrq_pkg::STATUS_CELL);
                state_d = S_EMIT;
              end else begin
                sq_start = 1'b1;
                state_d  = S_SQRT;
              end
            end
            default: begin
              cnt_d     = '0;
              clr_idx_d = '0;
              clr_res_d = 1'b1;
              state_d   = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        head_we   = 1'b1;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == '1) begin
          if (clr_res_q) begin
            rq_d    = ugrq_pkg::plain_res(ugrq_pkg::STATUS_CELL);
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_REG0: begin
        colw_d  = ugrq_pkg::div_trunc($signed({{3{req_q.x[23]}}, req_q.x})
                    - $signed({{3{cfg_i.origin_x[23]}}, cfg_i.origin_x}), cfg_i.shift);
        roww_d  = ugrq_pkg::div_trunc($signed({{3{req_q.z[23]}}, req_q.z})
                    - $signed({{3{cfg_i.origin_z[23]}}, cfg_i.origin_z}), cfg_i.shift);
        state_d = S_REG1;
      end
      S_REG1: begin
        cell_d = ({6'b0, roww_q[5:0]} * {6'b0, cfg_i.cols}) + {6'b0, colw_q[5:0]};
        ingrid_d = !colw_q[BW-1] && (colw_q < cols_s) && !roww_q[BW-1] && (roww_q < rows_s)
                   && ({1'b0, cell_d} < 13'(ugrq_pkg::MAX_CELLS));
        head_re    = 1'b1;
        head_raddr = cell_d[ugrq_pkg::CELL_AW-1:0];
        state_d    = S_REG2;
      end
      S_REG2: begin
        pt_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (ingrid_q) begin
          head_we    = 1'b1;
          head_waddr = cell_q[ugrq_pkg::CELL_AW-1:0];
          head_wdata = cnt_q;
        end
        rq_d    = ugrq_pkg::plain_res(ingrid_q ? ugrq_pkg::STATUS_CELL
                                               : ugrq_pkg::STATUS_OUTSIDE);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          clr_res_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          rad_d   = sq_root;
          state_d = S_BOUND;
        end
      end
      S_BOUND: begin
        if ((c0c > c1c) || (r0c > r1c)) begin
          state_d = S_DONE;
        end else begin
          c0_d = c0c[5:0];  c1_d = c1c[5:0];  r0_d = r0c[5:0];  r1_d = r1c[5:0];
          row_d = r0c[5:0];  col_d = c0c[5:0];
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        if ({1'b0, cell_now} < 13'(ugrq_pkg::MAX_CELLS)) begin
          head_re = 1'b1;
          state_d = S_HEAD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_HEAD: begin
        cur_d   = head_rd_q;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (cur_q < cnt_q) begin
          pt_re   = 1'b1;
          state_d = S_PDATA;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_PDATA: begin
        sqx_d   = {25'b0, adx} * {25'b0, adx};
        sqz_d   = {25'b0, adz} * {25'b0, adz};
        cid_d   = pt_rd_q.id;
        cnext_d = pt_rd_q.next;
        state_d = S_PCMP;
      end
      S_PCMP: begin
        if (!hit) begin
          cur_d   = cnext_q;
          state_d = S_WALK;
        end else begin
          res_valid_o = pv_q;
          res_o       = pend_res;
          if (!pv_q || res_ready_i) begin
            pv_d   = 1'b1;
            pid_d  = cid_q;
            pcnt_d = pcnt_q + 6'd1;
            if (pcnt_d == req_q.lim) begin
              state_d = S_DONE;
            end else begin
              cur_d   = cnext_q;
              state_d = S_WALK;
            end
          end
        end
      end
      S_NEXT: begin
        if (col_q == c1_q) begin
          if (row_q == r1_q) begin
            state_d = S_DONE;
          end else begin
            row_d   = row_q + 6'd1;
            col_d   = c0_q;
            state_d = S_CELL;
          end
        end else begin
          col_d   = col_q + 6'd1;
          state_d = S_CELL;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (pv_q) begin
          res_o      = pend_res;
          res_o.last = 1'b1;
        end else begin
          res_o = ugrq_pkg::plain_res(ugrq_pkg::STATUS_CELL);
        end
        if (res_ready_i) begin
          pv_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;  colw_q <= colw_d;  roww_q <= roww_d;  cell_q <= cell_d;
    ingrid_q <= ingrid_d;  rad_q <= rad_d;  c0_q <= c0_d;  c1_q <= c1_d;
    r0_q <= r0_d;  r1_q <= r1_d;  row_q <= row_d;  col_q <= col_d;  cur_q <= cur_d;
    sqx_q <= sqx_d;  sqz_q <= sqz_d;  cid_q <= cid_d;  cnext_q <= cnext_d;
    pid_q <= pid_d;  rq_q <= rq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      clr_idx_q <= '0;
      clr_res_q <= 1'b0;
      pv_q      <= 1'b0;
      pcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_idx_q <= clr_idx_d;
      clr_res_q <= clr_res_d;
      pv_q      <= pv_d;
      pcnt_q    <= pcnt_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/ugrq_res_queue.sv
`default_nettype none
// Result queue between the sequencer and the output port.
module ugrq_res_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire ugrq_pkg::res_t in_i,
  output logic                in_ready_o,
  output logic                empty_o,
  output ugrq_pkg::res_t      out_o,
  input  wire logic           pop_i
);
  ugrq_pkg::res_t mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o = (cnt_q != 3'd4);
  assign empty_o    = (cnt_q == 3'd0);
  assign out_o      = mem_q[rptr_q];
  assign wr         = in_valid_i && in_ready_o;
  assign rd         = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 2'd1;
      if (rd) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr) - 3'(rd);
    end
  end
endmodule
`default_nettype wire

// File: hdl/uniform_grid_radius_query_unit.sv
`default_nettype none
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------------
// request   | in        | push / full              | req_type, obj_id, pos_x, pos_z,
//           |           |                          | radius_sq, max_hits
// result    | out       | empty / pop              | status, hit_valid, hit_id, hit_count,
//           |           |                          | last
// config    | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A register request steps through S_REG0, S_REG1 and S_REG2; a clear sweeps the cell head
// memory, one cell a cycle. A query starts the square root, then computes the bounds, then
// for each covered cell reads its head and walks its list, one entry at a time through the
// single read port of the point memory; a cell beyond the head store is skipped. A hit waits
// while the result queue is full. After reset the head memory is swept before the first
// request is served; requests are queued meanwhile. Either side may stall: both ends have a
// four-beat queue.
module uniform_grid_radius_query_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         req_type_i,
  input  wire logic signed [31:0] obj_id_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic [47:0]        radius_sq_i,
  input  wire logic [5:0]         max_hits_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status_o,
  output logic                    hit_valid_o,
  output logic signed [31:0]      hit_id_o,
  output logic [5:0]              hit_count_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);
  logic [5:0]         cols_q, rows_q;
  logic signed [23:0] ox_q, oz_q;
  logic [4:0]         shift_q;
  ugrq_pkg::cfg_t     cfg;

  logic           req_valid, req_pop;
  ugrq_pkg::req_t req;
  logic           res_valid, res_ready;
  ugrq_pkg::res_t res, res_head;

  // Configuration is always taken; a zero grid size stands for the default size.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= ugrq_pkg::DEFAULT_GRID;
      rows_q  <= ugrq_pkg::DEFAULT_GRID;
      ox_q    <= -24'sd32768;
      oz_q    <= -24'sd32768;
      shift_q <= 5'd12;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ugrq_pkg::CFG_GRID_COLS:  cols_q  <= cfg_data_i[5:0];
        ugrq_pkg::CFG_GRID_ROWS:  rows_q  <= cfg_data_i[5:0];
        ugrq_pkg::CFG_ORIGIN_X:   ox_q    <= $signed(cfg_data_i);
        ugrq_pkg::CFG_ORIGIN_Z:   oz_q    <= $signed(cfg_data_i);
        ugrq_pkg::CFG_CELL_SHIFT: shift_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.cols     = (cols_q == 6'd0) ? ugrq_pkg::DEFAULT_GRID : cols_q;
    cfg.rows     = (rows_q == 6'd0) ? ugrq_pkg::DEFAULT_GRID : rows_q;
    cfg.origin_x = ox_q;
    cfg.origin_z = oz_q;
    cfg.shift    = shift_q;
  end

  ugrq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_type_i (req_type_i),
    .obj_id_i   (obj_id_i),
    .pos_x_i    (pos_x_i),
    .pos_z_i    (pos_z_i),
    .radius_sq_i(radius_sq_i),
    .max_hits_i (max_hits_i),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_pop_i  (req_pop)
  );

  ugrq_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_pop_o  (req_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  ugrq_res_queue u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(res_valid),
    .in_i      (res),
    .in_ready_o(res_ready),
    .empty_o   (empty),
    .out_o     (res_head),
    .pop_i     (pop)
  );

  assign status_o    = res_head.status;
  assign hit_valid_o = res_head.hit_valid;
  assign hit_id_o    = res_head.hit_id;
  assign hit_count_o = res_head.hit_count;
  assign last_o      = res_head.last;
endmodule
`default_nettype wire
